@@ src/wsg_pkg.sv @@
// Shared types, constants and tables for the waveform sample generator.
// No dependencies; used by the controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none
package wsg_pkg;

    localparam int MAX_BURST_DEF     = 64;
    localparam int OUT_FRAC_BITS_DEF = 24;

    localparam logic [31:0] ANGLE_STEP  = 32'd68356572;
    localparam logic [31:0] POS_STEP    = 32'd13421773;
    localparam logic [32:0] POS_MOD     = 33'd2684354560;
    localparam logic [31:0] POS_MID     = 32'd1342177280;
    localparam logic [31:0] LFSR_TAPS   = 32'h80200003;
    localparam logic [31:0] LFSR_SEED   = 32'd1;
    localparam logic signed [35:0] CORDIC_GAIN = 36'sd652032874;
    localparam int CORDIC_STEPS = 28;
    localparam logic [56:0] RECIP_TURN  = 57'd91746578227562540;
    localparam logic [33:0] SIN_EPS     = 34'd1073;
    localparam logic [32:0] POS_EPS     = 33'd134;
    localparam logic signed [35:0] ONE_Q30 = 36'sd1073741824;

    typedef enum logic [2:0] {
        WAVE_SINE     = 3'd0,
        WAVE_TRIANGLE = 3'd1,
        WAVE_SQUARE   = 3'd2,
        WAVE_NOISE    = 3'd3,
        WAVE_SINRECIP = 3'd4,
        WAVE_RECIPSIN = 3'd5
    } wave_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV1,
        ST_CORDIC,
        ST_DIV2,
        ST_FINISH,
        ST_OUTPUT
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic start;     // marks the start of a sample (the datapath does not read it)
        logic div1_init; // start reciprocal-angle divide
        logic div_step;  // one divider iteration
        logic cor_init;  // load CORDIC operands
        logic cor_step;  // one CORDIC iteration
        logic div2_init; // start reciprocal-sine divide
        logic finish;    // form sample, advance accumulators
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic cor_done;
        logic need_div1;
        logic need_cor;
        logic need_div2;
    } sts_t;

    // arctangent table in turn units
    function automatic logic [29:0] atan_turn(input logic [4:0] i);
        case (i)
            5'd0:  atan_turn = 30'd536870912;
            5'd1:  atan_turn = 30'd316933406;
            5'd2:  atan_turn = 30'd167458907;
            5'd3:  atan_turn = 30'd85004756;
            5'd4:  atan_turn = 30'd42667331;
            5'd5:  atan_turn = 30'd21354465;
            5'd6:  atan_turn = 30'd10680862;
            5'd7:  atan_turn = 30'd5340245;
            5'd8:  atan_turn = 30'd2670163;
            5'd9:  atan_turn = 30'd1335087;
            5'd10: atan_turn = 30'd667544;
            5'd11: atan_turn = 30'd333772;
            5'd12: atan_turn = 30'd166886;
            5'd13: atan_turn = 30'd83443;
            5'd14: atan_turn = 30'd41722;
            5'd15: atan_turn = 30'd20861;
            5'd16: atan_turn = 30'd10430;
            5'd17: atan_turn = 30'd5215;
            5'd18: atan_turn = 30'd2608;
            5'd19: atan_turn = 30'd1304;
            5'd20: atan_turn = 30'd652;
            5'd21: atan_turn = 30'd326;
            5'd22: atan_turn = 30'd163;
            5'd23: atan_turn = 30'd81;
            5'd24: atan_turn = 30'd41;
            5'd25: atan_turn = 30'd20;
            5'd26: atan_turn = 30'd10;
            5'd27: atan_turn = 30'd5;
            default: atan_turn = 30'd0;
        endcase
    endfunction

endpackage
`default_nettype wire

@@ src/wsg_ctrl.sv @@
// Controller state machine for the waveform sample generator.
// Depends on wsg_pkg; drives commands into wsg_datapath.
`timescale 1ns / 1ps
`default_nettype none
module wsg_ctrl #(
    parameter int MAX_BURST = wsg_pkg::MAX_BURST_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [6:0]    in_count,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic               out_last,
    input  wire wsg_pkg::sts_t sts,
    output wsg_pkg::cmd_t      cmd
);

    localparam logic [6:0] MAX_CNT = 7'(MAX_BURST);

    wsg_pkg::state_t state_reg, state_next;
    logic [6:0] left_reg, left_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        left_next  = left_reg;
        case (state_reg)
            wsg_pkg::ST_IDLE:
            begin
                if (in_valid && in_count != 7'd0) begin
                    state_next = wsg_pkg::ST_START;
                    left_next  = (in_count > MAX_CNT) ? MAX_CNT : in_count;
                end
            end
            wsg_pkg::ST_START:
            begin
                if (sts.need_div1)
                    state_next = wsg_pkg::ST_DIV1;
                else if (sts.need_cor)
                    state_next = wsg_pkg::ST_CORDIC;
                else
                    state_next = wsg_pkg::ST_FINISH;
            end
            wsg_pkg::ST_DIV1:
            begin
                if (sts.div_done)
                    state_next = wsg_pkg::ST_CORDIC;
            end
            wsg_pkg::ST_CORDIC:
            begin
                if (sts.cor_done)
                    state_next = sts.need_div2 ? wsg_pkg::ST_DIV2 : wsg_pkg::ST_FINISH;
            end
            wsg_pkg::ST_DIV2:
            begin
                if (sts.div_done)
                    state_next = wsg_pkg::ST_FINISH;
            end
            wsg_pkg::ST_FINISH:
            begin
                state_next = wsg_pkg::ST_OUTPUT;
            end
            wsg_pkg::ST_OUTPUT:
            begin
                if (!out_stall) begin
                    left_next  = left_reg - 7'd1;
                    state_next = (left_reg == 7'd1) ? wsg_pkg::ST_IDLE : wsg_pkg::ST_START;
                end
            end
            default: state_next = wsg_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        in_stall  = (state_reg != wsg_pkg::ST_IDLE);
        out_valid = (state_reg == wsg_pkg::ST_OUTPUT);
        out_last  = (left_reg == 7'd1);
        case (state_reg)
            wsg_pkg::ST_START:
            begin
                cmd.start     = 1'b1;
                cmd.div1_init = sts.need_div1;
                cmd.cor_init  = !sts.need_div1 && sts.need_cor;
            end
            wsg_pkg::ST_DIV1:
            begin
                cmd.div_step = !sts.div_done;
                cmd.cor_init = sts.div_done;
            end
            wsg_pkg::ST_CORDIC:
            begin
                cmd.cor_step  = !sts.cor_done;
                cmd.div2_init = sts.cor_done && sts.need_div2;
            end
            wsg_pkg::ST_DIV2:   cmd.div_step = !sts.div_done;
            wsg_pkg::ST_FINISH: cmd.finish   = 1'b1;
            default: ;
        endcase
    end

    // hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= wsg_pkg::ST_IDLE;
            left_reg  <= 7'd0;
        end else begin
            state_reg <= state_next;
            left_reg  <= left_next;
        end
    end

endmodule
`default_nettype wire

@@ src/wsg_datapath.sv @@
// Datapath: accumulators, noise register, CORDIC, restoring divider, output format.
// Depends on wsg_pkg; steered by wsg_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none
module wsg_datapath #(
    parameter int OUT_FRAC_BITS = wsg_pkg::OUT_FRAC_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [2:0]    waveform,
    input  wire wsg_pkg::cmd_t cmd,
    output wsg_pkg::sts_t      sts,
    output logic signed [47:0] sample
);

    localparam int DIV_W   = 64;
    localparam int NUM2_SH = 30 + OUT_FRAC_BITS;
    localparam logic signed [63:0] OUT_MAX = 64'sh00007FFFFFFFFFFF;
    localparam logic signed [63:0] OUT_MIN = -OUT_MAX - 64'sd1;

    logic [31:0] angle_reg, pos_reg, lfsr_reg;
    logic [31:0] lfsr_adv;
    logic signed [35:0] cx_reg, cy_reg, cz_reg;
    logic [4:0]  ci_reg;
    logic [DIV_W-1:0] q_reg, r_reg, d_reg;
    logic [6:0]  di_reg;
    logic        neg_reg;
    logic signed [47:0] sample_reg;

    // sign and magnitude of the centred position
    logic signed [32:0] p;
    logic [32:0] pmag;
    assign p    = $signed({1'b0, pos_reg}) - $signed({1'b0, wsg_pkg::POS_MID});
    assign pmag = p[32] ? 33'(-p) : 33'(p);

    // sign and magnitude of the CORDIC result
    logic [33:0] smag;
    assign smag = cy_reg[35] ? 34'(-cy_reg) : 34'(cy_reg);

    logic [2:0] wf;
    assign wf = waveform;
    assign sts.need_div1 = (wf == wsg_pkg::WAVE_SINRECIP) && (pmag > wsg_pkg::POS_EPS);
    assign sts.need_cor  = (wf == wsg_pkg::WAVE_SINE) || (wf == wsg_pkg::WAVE_RECIPSIN);
    assign sts.need_div2 = (wf == wsg_pkg::WAVE_RECIPSIN) && (smag > wsg_pkg::SIN_EPS);
    assign sts.cor_done  = (ci_reg == 5'(wsg_pkg::CORDIC_STEPS));
    assign sts.div_done  = (di_reg == 7'(DIV_W));

    // Galois noise step
    assign lfsr_adv = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ wsg_pkg::LFSR_TAPS) : (lfsr_reg >> 1);

    // CORDIC operand fold from a turn value
    function automatic logic signed [35:0] fold(input logic [31:0] t);
        logic signed [35:0] z;
        z = 36'(signed'(t));
        if (z > wsg_pkg::ONE_Q30)
            z = 36'sh080000000 - z;
        else if (z < -wsg_pkg::ONE_Q30)
            z = -36'sh080000000 - z;
        return z;
    endfunction

    // Q30 to output format, rounded half up and saturated
    function automatic logic signed [47:0] to_out(input logic signed [35:0] v);
        logic signed [63:0] w;
        if (OUT_FRAC_BITS >= 30)
            w = 64'(v) <<< (OUT_FRAC_BITS - 30);
        else
            w = (64'(v) + (64'sd1 <<< (29 - OUT_FRAC_BITS))) >>> (30 - OUT_FRAC_BITS);
        if (w > OUT_MAX) w = OUT_MAX;
        if (w < OUT_MIN) w = OUT_MIN;
        return 48'(w);
    endfunction

    // one restoring divider bit
    logic [DIV_W:0] r_sh;
    logic [DIV_W:0] r_sub;
    assign r_sh  = {r_reg, q_reg[DIV_W-1]};
    assign r_sub = r_sh - {1'b0, d_reg};

    // one CORDIC rotation
    logic signed [35:0] xs, ys;
    logic [29:0] at;
    assign xs = cx_reg >>> ci_reg;
    assign ys = cy_reg >>> ci_reg;
    assign at = wsg_pkg::atan_turn(ci_reg);

    logic [31:0] recip_t;
    assign recip_t = neg_reg ? 32'(33'h100000000 - {1'b0, q_reg[31:0]}) : q_reg[31:0];

    logic signed [35:0] tri_v, noise_v;
    logic [31:0] tt;
    assign tt      = angle_reg + 32'h40000000;
    assign tri_v   = tt[31] ? (36'sh0C0000000 - $signed({4'd0, tt}))
                            : ($signed({4'd0, tt}) - wsg_pkg::ONE_Q30);
    assign noise_v = $signed({4'd0, lfsr_adv >> 1}) - wsg_pkg::ONE_Q30;

    logic [32:0] np;
    assign np = {1'b0, pos_reg} + {1'b0, wsg_pkg::POS_STEP};

    logic signed [63:0] rs;
    assign rs = $signed(q_reg);

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            angle_reg <= '0;
            pos_reg   <= wsg_pkg::POS_MID;
            lfsr_reg  <= wsg_pkg::LFSR_SEED;
            ci_reg    <= 5'(wsg_pkg::CORDIC_STEPS);
            di_reg    <= 7'(DIV_W);
        end else begin
            if (cmd.finish) begin
                angle_reg <= angle_reg + wsg_pkg::ANGLE_STEP;
                pos_reg   <= (np >= wsg_pkg::POS_MOD) ? 32'(np - wsg_pkg::POS_MOD) : np[31:0];
                if (wf == wsg_pkg::WAVE_NOISE)
                    lfsr_reg <= lfsr_adv;
            end
            if (cmd.cor_init)
                ci_reg <= '0;
            else if (cmd.cor_step)
                ci_reg <= ci_reg + 5'd1;
            if (cmd.div1_init || cmd.div2_init)
                di_reg <= '0;
            else if (cmd.div_step)
                di_reg <= di_reg + 7'd1;
        end
    end

    // datapath payload
    always_ff @(posedge clk)
    begin
        // load divider
        if (cmd.div1_init) begin
            q_reg   <= 64'(wsg_pkg::RECIP_TURN);
            r_reg   <= '0;
            d_reg   <= 64'(pmag);
            neg_reg <= p[32];
        end else if (cmd.div2_init) begin
            q_reg   <= (64'd1 << NUM2_SH) + 64'(smag >> 1);
            r_reg   <= '0;
            d_reg   <= 64'(smag);
            neg_reg <= cy_reg[35];
        end else if (cmd.div_step) begin
            if (!r_sub[DIV_W]) begin
                r_reg <= r_sub[DIV_W-1:0];
                q_reg <= {q_reg[DIV_W-2:0], 1'b1};
            end else begin
                r_reg <= r_sh[DIV_W-1:0];
                q_reg <= {q_reg[DIV_W-2:0], 1'b0};
            end
        end
        // load or rotate CORDIC
        if (cmd.cor_init) begin
            cx_reg <= wsg_pkg::CORDIC_GAIN;
            cy_reg <= '0;
            cz_reg <= fold((wf == wsg_pkg::WAVE_SINRECIP) ? recip_t : angle_reg);
        end else if (cmd.cor_step) begin
            if (!cz_reg[35]) begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - $signed({6'd0, at});
            end else begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + $signed({6'd0, at});
            end
        end
        // form sample
        if (cmd.finish) begin
            case (wf)
                wsg_pkg::WAVE_SINE:     sample_reg <= to_out(cy_reg);
                wsg_pkg::WAVE_TRIANGLE: sample_reg <= to_out(tri_v);
                wsg_pkg::WAVE_SQUARE:
                    sample_reg <= to_out(angle_reg[31] ? -wsg_pkg::ONE_Q30 : wsg_pkg::ONE_Q30);
                wsg_pkg::WAVE_NOISE:    sample_reg <= to_out(noise_v);
                wsg_pkg::WAVE_SINRECIP:
                    sample_reg <= (pmag > wsg_pkg::POS_EPS) ? to_out(cy_reg) : '0;
                wsg_pkg::WAVE_RECIPSIN:
                begin
                    if (smag <= wsg_pkg::SIN_EPS)
                        sample_reg <= '0;
                    else if (rs > OUT_MAX)
                        sample_reg <= neg_reg ? 48'(OUT_MIN) : 48'(OUT_MAX);
                    else
                        sample_reg <= neg_reg ? 48'(-rs) : 48'(rs);
                end
                default: sample_reg <= '0;
            endcase
        end
    end

    assign sample = sample_reg;

endmodule
`default_nettype wire

@@ src/waveform_sample_generator.sv @@
// Waveform sample generator top level: configuration register, controller, datapath.
// Depends on wsg_pkg, wsg_ctrl and wsg_datapath.
//
// Usage: write the waveform code on the cfg channel (cfg_valid/cfg_ready) while
// idle. A request transfer on in_valid/in_stall with sample_count asks for
// 1..MAX_BURST samples (larger counts saturate, zero gives nothing). Samples
// leave on out_valid/out_stall with sample and last; last marks the burst's
// final sample.
// Per sample: triangle, square, noise, the unused codes and sin(1/x) near zero go
// straight to the finish state; sine and 1/sin(x) near zero first run the 28-step
// CORDIC; sin(1/x) and 1/sin(x) also run the restoring divider, before the CORDIC
// for sin(1/x) and after it for 1/sin(x). One burst is handled at a time; the next
// request is taken once the last sample has transferred.
// Reset clears the angle to zero, the position to abscissa zero, the noise
// register to 1 and the waveform to sine.
// While the receiver stalls, the sample is held and no work proceeds.
`timescale 1ns / 1ps
`default_nettype none
module waveform_sample_generator #(
    parameter int MAX_BURST     = wsg_pkg::MAX_BURST_DEF,
    parameter int OUT_FRAC_BITS = wsg_pkg::OUT_FRAC_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  waveform,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [6:0]  sample_count,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic signed [47:0] sample,
    output logic             last
);

    logic [2:0] waveform_reg;
    wsg_pkg::cmd_t cmd;
    wsg_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    // hold waveform selection
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            waveform_reg <= 3'(wsg_pkg::WAVE_SINE);
        else if (cfg_valid)
            waveform_reg <= waveform;
    end

    wsg_ctrl #(.MAX_BURST(MAX_BURST)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_count (sample_count),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_last (last),
        .sts      (sts),
        .cmd      (cmd)
    );

    wsg_datapath #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .waveform (waveform_reg),
        .cmd      (cmd),
        .sts      (sts),
        .sample   (sample)
    );

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for the waveform sample generator: random bursts under every
// waveform code, checked sample by sample against a behavioural predictor.
// Depends on wsg_pkg and waveform_sample_generator.
`timescale 1ns / 1ps
module testbench;

    localparam int  WATCHDOG_LIMIT = 20000;
    localparam int  DRAIN_CYCLES   = 200;
    localparam int  HOLD_CYCLES    = 1500;
    localparam int  IDLE_PCT       = 31;
    localparam longint SAT_MAX     = 64'sd140737488355327;
    localparam longint SAT_MIN     = -64'sd140737488355328;
    localparam longint Q30_ONE     = 64'sd1073741824;

    typedef struct {
        logic signed [47:0] value;
        logic               tail;
    } sample_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [2:0]        waveform;
    logic              in_valid;
    logic              in_stall;
    logic [6:0]        sample_count;
    logic              out_valid;
    logic              out_stall;
    logic signed [47:0] sample;
    logic              last;

    // generator state mirrored by the predictor
    logic [2:0]  gen_wave;
    logic [31:0] gen_angle;
    logic [31:0] gen_pos;
    logic [31:0] gen_lfsr;

    logic [6:0] burst_queue[$];
    sample_t    sample_queue[$];
    int         errors = 0;
    bit         calm;
    int         idle_cycles = 0;

    longint atan_tab[28] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
    };

    waveform_sample_generator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .waveform     (waveform),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_count (sample_count),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample       (sample),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint clamp48(input longint v);
        if (v > SAT_MAX) return SAT_MAX;
        if (v < SAT_MIN) return SAT_MIN;
        return v;
    endfunction

    // round half up from 30 fraction bits to 24, then saturate
    function automatic longint to_out_fmt(input longint v);
        return clamp48((v + 64'sd32) >>> 6);
    endfunction

    // rotate by the angle given in turn units; fold into the right half-plane first
    function automatic longint cordic_sin(input logic [31:0] turn);
        longint z;
        longint x;
        longint y;
        longint nx;
        z = turn;
        if (turn[31]) z = z - 64'sd4294967296;
        x = 652032874;
        y = 0;
        if (z > Q30_ONE)
            z = 64'sd2147483648 - z;
        else if (z < -Q30_ONE)
            z = -64'sd2147483648 - z;
        for (int i = 0; i < 28; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - atan_tab[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + atan_tab[i];
            end
            x = nx;
        end
        return y;
    endfunction

    // evaluate the current waveform at the abscissa, then advance it by one step
    function automatic longint next_value();
        longint v;
        longint p;
        longint s;
        longint unsigned mag;
        longint unsigned np;
        logic [31:0] t;
        v = 0;
        case (gen_wave)
            wsg_pkg::WAVE_SINE:
                v = to_out_fmt(cordic_sin(gen_angle));
            wsg_pkg::WAVE_TRIANGLE:
            begin
                t = gen_angle + 32'h40000000;
                v = t[31] ? 3 * Q30_ONE - longint'(t) : longint'(t) - Q30_ONE;
                v = to_out_fmt(v);
            end
            wsg_pkg::WAVE_SQUARE:
                v = to_out_fmt(gen_angle[31] ? -Q30_ONE : Q30_ONE);
            wsg_pkg::WAVE_NOISE:
            begin
                gen_lfsr = gen_lfsr[0] ? ((gen_lfsr >> 1) ^ wsg_pkg::LFSR_TAPS)
                                       : (gen_lfsr >> 1);
                v = to_out_fmt(longint'(gen_lfsr >> 1) - Q30_ONE);
            end
            wsg_pkg::WAVE_SINRECIP:
            begin
                p   = longint'(gen_pos) - longint'(wsg_pkg::POS_MID);
                mag = (p < 0) ? -p : p;
                if (mag > 134)
                begin
                    np = 64'd91746578227562540 / mag;
                    t  = np[31:0];
                    if (p < 0) t = -t;
                    v = to_out_fmt(cordic_sin(t));
                end
            end
            wsg_pkg::WAVE_RECIPSIN:
            begin
                s   = cordic_sin(gen_angle);
                mag = (s < 0) ? -s : s;
                if (mag > 1073)
                begin
                    np = ((64'd1 << 54) + mag / 2) / mag;
                    v  = clamp48(s < 0 ? -longint'(np) : longint'(np));
                end
            end
            default:
                v = 0;
        endcase
        gen_angle = gen_angle + wsg_pkg::ANGLE_STEP;
        np = longint'(gen_pos) + longint'(wsg_pkg::POS_STEP);
        if (np >= longint'(wsg_pkg::POS_MOD)) np = np - longint'(wsg_pkg::POS_MOD);
        gen_pos = np[31:0];
        return v;
    endfunction

    // expand one burst request into its expected samples
    task automatic predict_burst(input logic [6:0] count);
        int n;
        sample_t s;
        n = (count > 64) ? 64 : count;
        for (int k = 0; k < n; k++)
        begin
            s.value = next_value();
            s.tail  = (k == n - 1);
            sample_queue.push_back(s);
        end
    endtask

    task automatic report(input string msg);
        $display("%0t: mismatch: %s", $realtime, msg);
        errors++;
    endtask

    function automatic logic [6:0] random_count();
        int r;
        r = $urandom_range(99);
        if (r < 5)  return 7'd0;
        if (r < 10) return 7'($urandom_range(127, 65));
        if (r < 30) return 7'($urandom_range(64, 7));
        return 7'($urandom_range(6, 1));
    endfunction

    // request driver: present queued bursts, hold while stalled, predict on transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            sample_count <= '0;
        end
        else if (in_valid && in_stall)
        begin
            in_valid <= 1'b1;
        end
        else
        begin
            if (in_valid)
                predict_burst(sample_count);
            if (burst_queue.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                in_valid     <= 1'b1;
                sample_count <= burst_queue.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // sample receiver: random stalls plus one long hold-off once traffic is flowing
    int seen;
    int hold_left;
    bit held;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            seen      <= 0;
            hold_left <= 0;
            held      <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen <= seen + 1;
                if (sample_queue.size() == 0)
                    report($sformatf("unexpected sample %0d last %0b", sample, last));
                else
                begin
                    if (sample !== sample_queue[0].value)
                        report($sformatf("sample got %0d want %0d",
                                         sample, sample_queue[0].value));
                    if (last !== sample_queue[0].tail)
                        report($sformatf("last got %0b want %0b", last, sample_queue[0].tail));
                    void'(sample_queue.pop_front());
                end
            end
            if (!held && seen >= 300)
            begin
                held      <= 1'b1;
                hold_left <= HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // watchdog: end the run when nothing transfers for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_waveform(input logic [2:0] code);
        @(posedge clk);
        cfg_valid <= 1'b1;
        waveform  <= code;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        gen_wave = code;
    endtask

    task automatic wait_drained();
        while (burst_queue.size() > 0 || in_valid || sample_queue.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    logic [2:0] wave_plan[13] = '{wsg_pkg::WAVE_SINE, wsg_pkg::WAVE_TRIANGLE,
                                  wsg_pkg::WAVE_SQUARE, wsg_pkg::WAVE_NOISE,
                                  wsg_pkg::WAVE_SINRECIP, wsg_pkg::WAVE_RECIPSIN,
                                  3'd6, 3'd7,
                                  wsg_pkg::WAVE_SINRECIP, wsg_pkg::WAVE_NOISE,
                                  wsg_pkg::WAVE_TRIANGLE, wsg_pkg::WAVE_RECIPSIN,
                                  wsg_pkg::WAVE_SINE};
    logic [6:0] directed[7]  = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd65, 7'd2, 7'd33};

    initial
    begin
        calm        = 1'b0;
        gen_wave    = wsg_pkg::WAVE_SINE;
        gen_angle   = '0;
        gen_pos     = wsg_pkg::POS_MID;
        gen_lfsr    = wsg_pkg::LFSR_SEED;
        cfg_valid   = 1'b0;
        waveform    = '0;
        rst_n       = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // walk the waveform codes, draining between writes
        for (int ph = 0; ph < 13; ph++)
        begin
            write_waveform(wave_plan[ph]);
            calm = (ph == 2);
            if (ph == 0)
                foreach (directed[i]) burst_queue.push_back(directed[i]);
            else
            begin
                burst_queue.push_back(7'd1);
                burst_queue.push_back(7'd64);
            end
            for (int i = 0; i < 15; i++)
                burst_queue.push_back(random_count());
            wait_drained();
        end

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
